### rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_ON_CLK(label, !(cond), msg)

`endif

### rtl/lqpi_pkg.sv
// Types, constants and arithmetic helpers of the luma quarter-pel interpolator.
`timescale 1ns / 1ps
`default_nettype none
package lqpi_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned TAPS = 6;
  // Column field covers the widest window the block supports.
  localparam int unsigned COL_W = $clog2(16 + 5);
  localparam int unsigned HALF_W = 15;
  localparam int unsigned CENTRE_W = 21;

  typedef struct packed {
    logic       start_of_block;
    logic [1:0] frac_x;
    logic [1:0] frac_y;
    logic [1:0] width_code;
    logic [1:0] height_code;
    logic       picture_is_reference;
    logic [7:0] ref_pixel;
  } lqpi_in_t;

  typedef struct packed {
    logic [7:0] pred_pixel;
    logic       last_of_block;
  } lqpi_out_t;

  // Classified window pixel passed from the front to the filter pipeline.
  typedef struct packed {
    logic [7:0]       ref_pixel;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
    logic [1:0]       frac_x;
    logic [1:0]       frac_y;
  } lqpi_item_t;

  function automatic logic signed [15:0] tap6_px(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                                 logic [7:0] d, logic [7:0] e, logic [7:0] f);
    logic signed [15:0] ta, tb, tc, td, te, tf;
    ta = $signed({8'd0, a});
    tb = $signed({8'd0, b});
    tc = $signed({8'd0, c});
    td = $signed({8'd0, d});
    te = $signed({8'd0, e});
    tf = $signed({8'd0, f});
    return ta + tf - 16'sd5 * (tb + te) + 16'sd20 * (tc + td);
  endfunction

  function automatic logic signed [CENTRE_W-1:0] tap6_half(
      logic [HALF_W-1:0] a, logic [HALF_W-1:0] b, logic [HALF_W-1:0] c,
      logic [HALF_W-1:0] d, logic [HALF_W-1:0] e, logic [HALF_W-1:0] f);
    logic signed [CENTRE_W-1:0] ta, tb, tc, td, te, tf;
    ta = $signed({{(CENTRE_W-HALF_W){a[HALF_W-1]}}, a});
    tb = $signed({{(CENTRE_W-HALF_W){b[HALF_W-1]}}, b});
    tc = $signed({{(CENTRE_W-HALF_W){c[HALF_W-1]}}, c});
    td = $signed({{(CENTRE_W-HALF_W){d[HALF_W-1]}}, d});
    te = $signed({{(CENTRE_W-HALF_W){e[HALF_W-1]}}, e});
    tf = $signed({{(CENTRE_W-HALF_W){f[HALF_W-1]}}, f});
    return ta + tf - 21'sd5 * (tb + te) + 21'sd20 * (tc + td);
  endfunction

  // Round by 16, shift by 5, clip to 0..255.
  function automatic logic [7:0] clip5(logic signed [15:0] v);
    logic signed [16:0] t;
    t = $signed({v[15], v}) + 17'sd16;
    if (t < 0) return 8'd0;
    if (t[16:13] != 4'd0) return 8'd255;
    return t[12:5];
  endfunction

  // Round by 512, shift by 10, clip to 0..255.
  function automatic logic [7:0] clip10(logic signed [CENTRE_W-1:0] v);
    logic signed [CENTRE_W:0] t;
    t = $signed({v[CENTRE_W-1], v}) + 22'sd512;
    if (t < 0) return 8'd0;
    if (t[CENTRE_W:18] != '0) return 8'd255;
    return t[17:10];
  endfunction

  function automatic logic [7:0] avg2(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // Pick the sample for the quarter position {frac_y, frac_x}.
  function automatic logic [7:0] pred_sel(logic [1:0] fy, logic [1:0] fx,
      logic [7:0] g, logic [7:0] hp, logic [7:0] mp, logic [7:0] b, logic [7:0] h,
      logic [7:0] j, logic [7:0] m, logic [7:0] s);
    logic [7:0] r;
    case ({fy, fx})
      4'd0:    r = g;
      4'd1:    r = avg2(g, b);
      4'd2:    r = b;
      4'd3:    r = avg2(b, hp);
      4'd4:    r = avg2(g, h);
      4'd5:    r = avg2(b, h);
      4'd6:    r = avg2(b, j);
      4'd7:    r = avg2(b, m);
      4'd8:    r = h;
      4'd9:    r = avg2(h, j);
      4'd10:   r = j;
      4'd11:   r = avg2(j, m);
      4'd12:   r = avg2(h, mp);
      4'd13:   r = avg2(h, s);
      4'd14:   r = avg2(j, s);
      default: r = avg2(m, s);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/lqpi_front.sv
// Front end: window position tracking, block settings and item classification.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lqpi_front #(
  parameter int unsigned MAX_BLOCK = lqpi_pkg::MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lqpi_pkg::lqpi_in_t   in_data_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lqpi_pkg::lqpi_item_t item_o
);
  import lqpi_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BLOCK + 5);

  logic [1:0]    mode_q;
  logic          busy_q;
  logic [1:0]    fx_q, fy_q;
  logic [CW-1:0] wl_q, hl_q, col_q, row_q;
  logic [CW-1:0] cur_c, cur_r, wl, hl;
  logic [1:0]    fx, fy;
  logic          acc, start, force_full, active, last;

  // Index of the last window column or row for a size code.
  function automatic logic [CW-1:0] last_idx(logic [1:0] code);
    logic [4:0] s;
    s = (code >= 2'd2) ? 5'd16 : (5'd4 << code);
    if (32'(s) > MAX_BLOCK) s = 5'(MAX_BLOCK);
    return CW'(s + 5'd4);
  endfunction

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign start      = in_data_i.start_of_block;
  assign force_full = mode_q[0] | (mode_q[1] & ~in_data_i.picture_is_reference);
  assign active     = start | busy_q;

  always_comb begin
    cur_c = start ? '0 : col_q;
    cur_r = start ? '0 : row_q;
    wl    = start ? last_idx(in_data_i.width_code) : wl_q;
    hl    = start ? last_idx(in_data_i.height_code) : hl_q;
    fx    = start ? (force_full ? 2'd0 : in_data_i.frac_x) : fx_q;
    fy    = start ? (force_full ? 2'd0 : in_data_i.frac_y) : fy_q;
    last  = (cur_r == hl) && (cur_c == wl);
  end

  assign push_o           = acc && active;
  assign item_o.ref_pixel = in_data_i.ref_pixel;
  assign item_o.col       = COL_W'(cur_c);
  assign item_o.emit      = (cur_r >= CW'(5)) && (cur_c >= CW'(5));
  assign item_o.last      = last;
  assign item_o.frac_x    = fx;
  assign item_o.frac_y    = fy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      busy_q <= 1'b0;
      fx_q   <= '0;
      fy_q   <= '0;
      wl_q   <= '0;
      hl_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (acc && active) begin
        fx_q <= fx;
        fy_q <= fy;
        wl_q <= wl;
        hl_q <= hl;
        if (last) begin
          busy_q <= 1'b0;
          col_q  <= '0;
          row_q  <= '0;
        end else if (cur_c == wl) begin
          busy_q <= 1'b1;
          col_q  <= '0;
          row_q  <= cur_r + CW'(1);
        end else begin
          busy_q <= 1'b1;
          col_q  <= cur_c + CW'(1);
          row_q  <= cur_r;
        end
      end
    end
  end

  `ASSERT_ON_CLK(a_last_ends_block, push_o && item_o.last |=> !busy_q, "block still busy after last")
  `ASSERT_ON_CLK(a_start_opens_block, acc && start |=> busy_q, "block start did not open block")
  `ASSERT_ON_CLK(a_emit_inside, push_o && item_o.emit |-> cur_c <= wl, "output past window edge")

endmodule
`default_nettype wire

### rtl/lqpi_queue.sv
// Short FIFO that decouples the front end from the filter pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lqpi_queue #(
  parameter int unsigned DEPTH = lqpi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lqpi_pkg::lqpi_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output lqpi_pkg::lqpi_item_t item_o
);
  import lqpi_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  lqpi_item_t    slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + NW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - NW'(1);
    end
  end

  `ASSERT_NEVER(a_count_range, cnt_q > NW'(DEPTH), "queue count past depth")
  `ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")

endmodule
`default_nettype wire

### rtl/lqpi_back.sv
// Filter pipeline: line buffers, 6-tap filters, quarter-pel select and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lqpi_back #(
  parameter int unsigned MAX_BLOCK = lqpi_pkg::MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  lqpi_pkg::lqpi_item_t q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lqpi_pkg::lqpi_out_t  out_data_o
);
  import lqpi_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_BLOCK + 5);
  localparam int unsigned HIW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  // Column stacks of the five rows above the current one, newest first.
  logic [TAPS-2:0][7:0]        pix_mem_q  [MAX_BLOCK + 5];
  logic [TAPS-2:0][HALF_W-1:0] half_mem_q [MAX_BLOCK];

  logic       en;
  logic [4:1] vld_q;
  lqpi_item_t it1_q, it2_q, it3_q, it4_q;

  // Stage 1
  logic [CW-1:0]               pidx;
  logic [TAPS-2:0][7:0]        prd;
  logic [TAPS-1:0][7:0]        vec_c;
  logic [TAPS-2:0][7:0]        hp_q;
  logic [TAPS-1:0][7:0]        vs1_q, vs2_q, vs3_q;
  logic signed [15:0]          hsum, vsum_h, vsum_m;
  // Stage 2
  logic [HALF_W-1:0]           hcur2_q;
  logic signed [15:0]          vh2_q, vm2_q;
  logic [7:0]                  g2_q, hp2_q, mp2_q;
  logic [COL_W-1:0]            colm5;
  logic [HIW-1:0]              hidx;
  logic [TAPS-2:0][HALF_W-1:0] hrd;
  logic [TAPS-1:0][HALF_W-1:0] hvec;
  logic signed [CENTRE_W-1:0]  jsum;
  // Stage 3
  logic signed [CENTRE_W-1:0]  j3_q;
  logic [HALF_W-1:0]           hb3_q, hs3_q;
  logic [7:0]                  h3_q, m3_q, g3_q, hp3_q, mp3_q;
  // Stage 4
  logic [7:0]                  j4_q, b4_q, s4_q, h4_q, m4_q, g4_q, hp4_q, mp4_q;
  // Output
  logic                        out_valid_q;
  lqpi_out_t                   out_q;

  // Advance the whole pipeline unless the output register holds a result that is not taken.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_valid_i;

  assign pidx   = it1_q.col[CW-1:0];
  assign prd    = pix_mem_q[pidx];
  assign vec_c  = {prd, it1_q.ref_pixel};
  assign hsum   = tap6_px(hp_q[4], hp_q[3], hp_q[2], hp_q[1], hp_q[0], it1_q.ref_pixel);
  assign vsum_h = tap6_px(vs3_q[5], vs3_q[4], vs3_q[3], vs3_q[2], vs3_q[1], vs3_q[0]);
  assign vsum_m = tap6_px(vs2_q[5], vs2_q[4], vs2_q[3], vs2_q[2], vs2_q[1], vs2_q[0]);

  assign colm5 = it2_q.col - COL_W'(5);
  assign hidx  = colm5[HIW-1:0];
  assign hrd   = half_mem_q[hidx];
  assign hvec  = {hrd, hcur2_q};
  assign jsum  = tap6_half(hvec[5], hvec[4], hvec[3], hvec[2], hvec[1], hvec[0]);

  always_ff @(posedge clk_i) begin
    if (en && vld_q[1]) begin
      pix_mem_q[pidx] <= {prd[TAPS-3:0], it1_q.ref_pixel};
      hp_q  <= {hp_q[TAPS-3:0], it1_q.ref_pixel};
      vs1_q <= vec_c;
      vs2_q <= vs1_q;
      vs3_q <= vs2_q;
    end
    if (en && vld_q[2] && (it2_q.col >= COL_W'(5))) begin
      half_mem_q[hidx] <= {hrd[TAPS-3:0], hcur2_q};
    end
    if (en) begin
      it1_q   <= q_item_i;
      it2_q   <= it1_q;
      hcur2_q <= hsum[HALF_W-1:0];
      vh2_q   <= vsum_h;
      vm2_q   <= vsum_m;
      g2_q    <= vs3_q[3];
      hp2_q   <= vs2_q[3];
      mp2_q   <= vs3_q[2];
      it3_q   <= it2_q;
      j3_q    <= jsum;
      hb3_q   <= hvec[3];
      hs3_q   <= hvec[2];
      h3_q    <= clip5(vh2_q);
      m3_q    <= clip5(vm2_q);
      g3_q    <= g2_q;
      hp3_q   <= hp2_q;
      mp3_q   <= mp2_q;
      it4_q   <= it3_q;
      j4_q    <= clip10(j3_q);
      b4_q    <= clip5($signed({hb3_q[HALF_W-1], hb3_q}));
      s4_q    <= clip5($signed({hs3_q[HALF_W-1], hs3_q}));
      h4_q    <= h3_q;
      m4_q    <= m3_q;
      g4_q    <= g3_q;
      hp4_q   <= hp3_q;
      mp4_q   <= mp3_q;
    end
    if (en && vld_q[4] && it4_q.emit) begin
      out_q.pred_pixel    <= pred_sel(it4_q.frac_y, it4_q.frac_x, g4_q, hp4_q, mp4_q,
                                      b4_q, h4_q, j4_q, m4_q, s4_q);
      out_q.last_of_block <= it4_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[3:1], q_valid_i};
      out_valid_q <= vld_q[4] && it4_q.emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ON_CLK(a_freeze_on_stall, !en |=> $stable(vld_q), "pipeline moved while stalled")
  `ASSERT_ON_CLK(a_result_loaded, en && vld_q[4] && it4_q.emit |=> out_valid_q, "result lost")
  `ASSERT_ON_CLK(a_result_source, $rose(out_valid_q) |-> $past(vld_q[4] && it4_q.emit),
                 "result without item")

endmodule
`default_nettype wire

### rtl/luma_quarter_pel_interpolator.sv
// Path: an accepted pixel is queued, then passes stages 1 to 4 and the output register.
// Throughput: one window pixel per cycle unless the queue is full; a WxH block takes
// (W+5)*(H+5) pixels, W*H results. The rate is set by the five-stage filter pipeline fed
// from a four-entry queue. Reset clears position, block settings, mode, queue and pipeline
// valids; line buffers are not cleared and are rewritten before emitted results use them.
`timescale 1ns / 1ps
`default_nettype none
module luma_quarter_pel_interpolator #(
  parameter int unsigned MAX_BLOCK   = lqpi_pkg::MAX_BLOCK_DEF,
  parameter int unsigned QUEUE_DEPTH = lqpi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lqpi_pkg::lqpi_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lqpi_pkg::lqpi_out_t out_data_o
);
  import lqpi_pkg::*;

  logic       push, full, q_valid, pop;
  lqpi_item_t push_item, q_item;

  lqpi_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .q_full_i(full), .push_o(push), .item_o(push_item)
  );

  lqpi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(push_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  lqpi_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire
